/* hw/rtl/rc_pkg.sv */
// Package for the radix converter: item types, register indexes, back-end states
// and the character/digit helper functions. No dependencies.
`timescale 1ns / 1ps

package rc_pkg;

  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned MaxDigitsDef = 32;
  localparam int unsigned BaseW        = 5;
  localparam int unsigned CharW        = 8;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [BaseW-1:0] BaseMin   = BaseW'(2);
  localparam logic [BaseW-1:0] BaseMax   = BaseW'(17);
  localparam logic [BaseW-1:0] InBaseRst = BaseW'(10);
  localparam logic [BaseW-1:0] OutBaseRst = BaseW'(2);

  localparam logic [CharW-1:0] CharZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [CharW-1:0] CharUpG   = 8'h47;  // 'G'
  localparam logic [CharW-1:0] CharComma = 8'h2C;  // ','
  localparam logic [CharW-1:0] CharDot   = 8'h2E;  // '.'

  typedef enum logic [CfgIdxW-1:0] {
    CfgInBase  = 1'b0,
    CfgOutBase = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StRead,
    StSend
  } back_state_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last_digit;
    logic             overflow;
    logic             invalid;
  } out_item_t;

  // Status that travels with a finished numeral from front to back.
  typedef struct packed {
    logic overflow;
    logic invalid;
  } job_flags_t;

  typedef struct packed {
    logic             valid;
    logic [BaseW-1:0] value;
  } digit_t;

  function automatic logic [BaseW-1:0] clamp_base(input logic [BaseW-1:0] b);
    logic [BaseW-1:0] r;
    if (b < BaseMin) begin
      r = BaseMin;
    end else if (b > BaseMax) begin
      r = BaseMax;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic digit_t char_to_digit(input logic [CharW-1:0] c);
    digit_t r;
    logic [CharW-1:0] diff;
    r.valid = 1'b0;
    r.value = '0;
    if (c >= CharZero && c <= CharNine) begin
      diff    = c - CharZero;
      r.valid = 1'b1;
      r.value = diff[BaseW-1:0];
    end else if (c >= CharUpA && c <= CharUpG) begin
      diff    = c - CharUpA + CharW'(10);
      r.valid = 1'b1;
      r.value = diff[BaseW-1:0];
    end
    return r;
  endfunction

  function automatic logic [CharW-1:0] digit_to_char(input logic [BaseW-1:0] d);
    logic [CharW-1:0] r;
    if (d < BaseW'(10)) begin
      r = CharZero + CharW'(d);
    end else begin
      r = CharUpA + CharW'(d) - CharW'(10);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rc_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rc_front.sv */
// Front end of the radix converter: takes characters, accumulates the integer value
// and hands finished numerals to the job queue. Depends on rc_pkg.
`timescale 1ns / 1ps

module rc_front import rc_pkg::*; #(
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BaseW-1:0]     in_base_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 push_o,
  output logic [ValueBits-1:0] push_value_o,
  output job_flags_t           push_flags_o,
  input  logic                 queue_full_i
);

  localparam int unsigned ProdW = ValueBits + BaseW + 1;

  logic [ValueBits-1:0] acc_q, acc_d;
  logic                 frac_q, frac_d;
  logic                 ovf_q, ovf_d;
  logic                 inv_q, inv_d;

  logic                 accept;
  logic [BaseW-1:0]     base;
  digit_t               dig;
  logic [ProdW-1:0]     full_sum;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign base       = clamp_base(in_base_i);
  assign dig        = char_to_digit(in_item_i.char_code);
  assign full_sum   = ProdW'(acc_q) * ProdW'(base) + ProdW'(dig.value);

  // Absorb one character into the numeral state.
  always_comb begin
    acc_d  = acc_q;
    frac_d = frac_q;
    ovf_d  = ovf_q;
    inv_d  = inv_q;
    if (!frac_q) begin
      if (in_item_i.char_code == CharComma || in_item_i.char_code == CharDot) begin
        frac_d = 1'b1;
      end else if (!dig.valid || dig.value >= base) begin
        inv_d = 1'b1;
      end else if (full_sum[ProdW-1:ValueBits] != '0) begin
        acc_d = '1;
        ovf_d = 1'b1;
      end else begin
        acc_d = full_sum[ValueBits-1:0];
      end
    end
  end

  assign push_o                = accept && in_item_i.last_char;
  assign push_value_o          = acc_d;
  assign push_flags_o.overflow = ovf_d;
  assign push_flags_o.invalid  = inv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      frac_q <= 1'b0;
      ovf_q  <= 1'b0;
      inv_q  <= 1'b0;
    end else if (accept) begin
      if (in_item_i.last_char) begin
        acc_q  <= '0;
        frac_q <= 1'b0;
        ovf_q  <= 1'b0;
        inv_q  <= 1'b0;
      end else begin
        acc_q  <= acc_d;
        frac_q <= frac_d;
        ovf_q  <= ovf_d;
        inv_q  <= inv_d;
      end
    end
  end

endmodule

/* hw/rtl/rc_queue.sv */
// Short register FIFO that holds finished numerals between front and back end.
// Depends on rc_pkg for the default depth.
`timescale 1ns / 1ps

module rc_queue import rc_pkg::*; #(
  parameter int unsigned Width = ValueBitsDef + 2,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* hw/rtl/rc_back.sv */
// Back end of the radix converter: splits a numeral into output digits by
// bit-serial division, stores them in the digit RAM and emits them MSD first.
// Depends on rc_pkg and rc_ram.
`timescale 1ns / 1ps

module rc_back import rc_pkg::*; #(
  parameter int unsigned ValueBits = ValueBitsDef,
  parameter int unsigned MaxDigits = MaxDigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BaseW-1:0]     out_base_i,
  input  logic                 job_empty_i,
  input  logic [ValueBits-1:0] job_value_i,
  input  job_flags_t           job_flags_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  localparam int unsigned AddrW = $clog2(MaxDigits);
  localparam int unsigned CntW  = $clog2(MaxDigits + 1);
  localparam int unsigned BitW  = (ValueBits > 1) ? $clog2(ValueBits) : 1;

  back_state_e          state_q, state_d;
  logic [ValueBits-1:0] val_q;
  logic [BaseW-1:0]     rem_q;
  logic [BitW-1:0]      bit_q;
  logic [CntW-1:0]      cnt_q;
  logic [AddrW-1:0]     rd_idx_q;
  job_flags_t           flags_q;

  logic [BaseW-1:0]     base;
  logic [BaseW:0]       trial;
  logic                 q_bit;
  logic [BaseW:0]       trial_sub;
  logic [BaseW-1:0]     rem_next;
  logic [ValueBits-1:0] quot_next;
  logic                 digit_done;
  logic                 conv_done;
  logic                 ram_we;
  logic                 ram_re;
  logic [BaseW-1:0]     ram_rdata;

  assign base       = clamp_base(out_base_i);
  assign trial      = {rem_q, val_q[ValueBits-1]};
  assign q_bit      = (trial >= {1'b0, base});
  assign trial_sub  = trial - {1'b0, base};
  assign rem_next   = q_bit ? trial_sub[BaseW-1:0] : trial[BaseW-1:0];
  assign quot_next  = {val_q[ValueBits-2:0], q_bit};
  assign digit_done = (bit_q == BitW'(ValueBits - 1));
  assign conv_done  = digit_done &&
                      ((quot_next == '0) || (cnt_q == CntW'(MaxDigits - 1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!job_empty_i) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (conv_done) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StSend;
      end
      StSend: begin
        if (!out_stall_i) begin
          state_d = (rd_idx_q == '0) ? StIdle : StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        pop_o = !job_empty_i;
      end
      StDiv: begin
        ram_we = digit_done;
      end
      StRead: begin
        ram_re = 1'b1;
      end
      StSend: begin
        out_valid_o = 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      val_q    <= '0;
      rem_q    <= '0;
      bit_q    <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      flags_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          val_q   <= job_value_i;
          flags_q <= job_flags_i;
          rem_q   <= '0;
          bit_q   <= '0;
          cnt_q   <= '0;
        end
        StDiv: begin
          val_q <= quot_next;
          if (digit_done) begin
            rem_q    <= '0;
            bit_q    <= '0;
            cnt_q    <= cnt_q + CntW'(1);
            rd_idx_q <= cnt_q[AddrW-1:0];
            if (conv_done && quot_next != '0) begin
              flags_q.overflow <= 1'b1;
            end
          end else begin
            rem_q <= rem_next;
            bit_q <= bit_q + BitW'(1);
          end
        end
        StSend: begin
          if (!out_stall_i && rd_idx_q != '0) begin
            rd_idx_q <= rd_idx_q - AddrW'(1);
          end
        end
        default: begin
          bit_q <= bit_q;
        end
      endcase
    end
  end

  rc_ram #(
    .Width(BaseW),
    .Depth(MaxDigits)
  ) u_digit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i(rem_next),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign out_item_o.digit_char = digit_to_char(ram_rdata);
  assign out_item_o.last_digit = (rd_idx_q == '0);
  assign out_item_o.overflow   = flags_q.overflow;
  assign out_item_o.invalid    = flags_q.invalid;

endmodule

/* hw/rtl/radix_converter.sv */
// Top level of the radix converter: configuration registers, front end, job queue
// and back end. Depends on rc_pkg, rc_front, rc_queue, rc_back and rc_ram.
//
// Usage: the input channel carries one ASCII character per item, with last_char
// marking the end of a numeral. Digits '0'-'9' and 'A'-'G' below in_base are
// accumulated; characters after the first ',' or '.' are ignored. The front end
// takes one character every cycle while the job queue is not full. When the last
// character of a numeral is taken, the numeral moves into a two-entry job queue,
// so the next numeral can stream in while the back end is still busy with the
// previous one. The back end divides by out_base one quotient bit per cycle,
// writing each finished output digit into the digit RAM. Once the numeral is
// fully divided, it reads the digits back from the digit RAM one at a time in the
// read state and presents each in the send state. Each digit item carries the
// overflow and invalid flags of its numeral, and last_digit marks the least
// significant digit. While out_stall_i is high the presented digit holds; once
// the queue is full, in_stall_o goes high. Reset sets in_base to 10 and out_base
// to 2 and empties the queue. The configuration port is always ready; write it
// only while the block is idle.
`timescale 1ns / 1ps

module radix_converter import rc_pkg::*; #(
  parameter int unsigned ValueBits = ValueBitsDef,
  parameter int unsigned MaxDigits = MaxDigitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [BaseW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  localparam int unsigned JobW = ValueBits + 2;

  logic [BaseW-1:0]     in_base_q;
  logic [BaseW-1:0]     out_base_q;

  logic                 push;
  logic [ValueBits-1:0] push_value;
  job_flags_t           push_flags;
  logic                 queue_full;
  logic                 queue_empty;
  logic                 pop;
  logic [JobW-1:0]      job_word;
  job_flags_t           job_flags;

  // Configuration registers. The port never needs to wait.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_base_q  <= InBaseRst;
      out_base_q <= OutBaseRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgInBase: begin
          in_base_q <= cfg_data_i;
        end
        CfgOutBase: begin
          out_base_q <= cfg_data_i;
        end
        default: begin
          in_base_q <= in_base_q;
        end
      endcase
    end
  end

  rc_front #(
    .ValueBits(ValueBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_base_i   (in_base_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_value_o(push_value),
    .push_flags_o(push_flags),
    .queue_full_i(queue_full)
  );

  // Each queued job is the final value with its two status flags below it.
  rc_queue #(
    .Width(JobW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_value, push_flags}),
    .full_o (queue_full),
    .pop_i  (pop),
    .empty_o(queue_empty),
    .rdata_o(job_word)
  );

  assign job_flags = job_flags_t'(job_word[1:0]);

  rc_back #(
    .ValueBits(ValueBits),
    .MaxDigits(MaxDigits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .out_base_i (out_base_q),
    .job_empty_i(queue_empty),
    .job_value_i(job_word[JobW-1:2]),
    .job_flags_i(job_flags),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
